/* src/wstat_pkg.sv */
`default_nettype none

package wstat_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int MAX_SAMPLES_DEF = 256;

   localparam int MEAN_W  = 24;
   localparam int STD_W   = 24;
   localparam int TOTAL_W = 24;
   localparam int MAGT_W  = 24;
   localparam int COUNT_W = 9;

   localparam int Q_FRAC   = 8;
   localparam int VAR_FRAC = 2 * Q_FRAC;

   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_TOP =
      {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_BOTTOM =
      {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_PASS,
      ST_MUL_NSQ,
      ST_MUL_SS,
      ST_MUL_NN,
      ST_MEAN_INIT,
      ST_DIV_MEAN,
      ST_MEAN_FIX,
      ST_DIV_VAR,
      ST_ROOT,
      ST_OUT
   } wstat_state_type;

endpackage

`default_nettype wire

/* src/window_statistics_unit.sv */
// Window statistics over signed accelerometer samples. Samples may arrive
// back to back while req_ready is high; each one is written into an internal
// sample memory of MAX_SAMPLES entries while the sum, sum of magnitudes,
// minimum and maximum are updated; samples past capacity are dropped and
// reported through rsp_overflow. The sample marked req_last_sample starts the
// closing sequence, during which req_ready is low: a second pass over the
// memory forms the sum of squares through one shared multiplier, three
// multiplier steps and a setup step follow, then one shared subtractor runs
// two restoring divisions of WK_W steps each (mean, then variance with a fix
// step between them) and a square root of WK_W/2 steps. With the default
// capacity WK_W is 66. A final step moves the result into the output
// register. The output register holds the result until taken while the
// cleared window loads the next samples; a window that closes while the
// previous result still waits holds its result and keeps req_ready low until
// that result is taken.
`default_nettype none

module window_statistics_unit #(
   parameter int MAX_SAMPLES = wstat_pkg::MAX_SAMPLES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [wstat_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input  logic                                   req_last_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [wstat_pkg::MEAN_W-1:0]    rsp_mean_q8,
   output logic        [wstat_pkg::STD_W-1:0]     rsp_std_dev_q8,
   output logic signed [wstat_pkg::SAMPLE_WIDTH-1:0] rsp_minimum,
   output logic signed [wstat_pkg::SAMPLE_WIDTH-1:0] rsp_maximum,
   output logic signed [wstat_pkg::TOTAL_W-1:0]   rsp_total,
   output logic        [wstat_pkg::MAGT_W-1:0]    rsp_magnitude_total,
   output logic        [wstat_pkg::COUNT_W-1:0]   rsp_sample_count,
   output logic                                   rsp_overflow
);
   import wstat_pkg::*;

   localparam int SW     = SAMPLE_WIDTH;
   localparam int CW     = $clog2(MAX_SAMPLES + 1);
   localparam int AW     = $clog2(MAX_SAMPLES);
   localparam int SUM_W  = SW + CW;
   localparam int SMAG_W = SUM_W - 1;
   localparam int MAG_W  = SW;
   localparam int SQ_W   = 2 * SW + CW - 1;
   localparam int P_W    = SMAG_W + SQ_W;
   localparam int NUM_W  = CW + SQ_W;
   localparam int DVR_W  = 2 * CW;
   localparam int DVD_W  = NUM_W + VAR_FRAC;
   localparam int WK_W   = DVD_W + (DVD_W % 2);
   localparam int RT_W   = WK_W / 2;
   localparam int SUB_W  = (DVR_W + 1 > RT_W + 3) ? DVR_W + 1 : RT_W + 3;
   localparam int STEP_W = $clog2(WK_W + 1);

   logic [SW-1:0] mem [MAX_SAMPLES];

   wstat_state_type state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SMAG_W-1:0]        abs_ff, abs_in;
   logic signed [SW-1:0]     min_ff, min_in;
   logic signed [SW-1:0]     max_ff, max_in;
   logic                     drop_ff, drop_in;
   logic                     rd_vld_ff, rd_vld_in;
   logic                     prod_vld_ff, prod_vld_in;
   logic                     out_vld_ff, out_vld_in;

   logic [CW-1:0]            idx_ff, idx_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic [NUM_W-1:0]         num_ff, num_in;
   logic [DVR_W-1:0]         nsq_ff, nsq_in;
   logic [WK_W-1:0]          wk_ff, wk_in;
   logic [SUB_W-1:0]         rem_ff, rem_in;
   logic [RT_W-1:0]          root_ff, root_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [MEAN_W-1:0]        mean_ff, mean_in;
   logic [P_W-1:0]           prod_ff;
   logic signed [SW-1:0]     rd_data_ff;

   logic [MEAN_W-1:0]        out_mean_ff;
   logic [STD_W-1:0]         out_std_ff;
   logic signed [SW-1:0]     out_min_ff;
   logic signed [SW-1:0]     out_max_ff;
   logic [TOTAL_W-1:0]       out_total_ff;
   logic [MAGT_W-1:0]        out_magt_ff;
   logic [COUNT_W-1:0]       out_count_ff;
   logic                     out_drop_ff;

   logic                     mem_we;
   logic                     issue;
   logic                     out_load;
   logic [MAG_W-1:0]         smp_mag;
   logic [MAG_W-1:0]         rd_mag;
   logic [SUM_W-1:0]         sum_abs;
   logic [SMAG_W-1:0]        smag;
   logic [SMAG_W-1:0]        mul_a;
   logic [SQ_W-1:0]          mul_b;
   logic [SUB_W-1:0]         sub_a;
   logic [SUB_W-1:0]         sub_b;
   logic [SUB_W:0]           diff;
   logic                     ge;
   logic [DVR_W-1:0]         divisor;
   logic [MEAN_W-1:0]        q_low;
   logic [MEAN_W-1:0]        q_adj;

   assign smp_mag = req_sample[SW-1] ? MAG_W'(-req_sample) : MAG_W'(req_sample);
   assign rd_mag  = rd_data_ff[SW-1] ? MAG_W'(-rd_data_ff) : MAG_W'(rd_data_ff);
   assign sum_abs = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign smag    = sum_abs[SMAG_W-1:0];
   assign divisor = (state_ff == ST_DIV_MEAN) ? DVR_W'(count_ff) : nsq_ff;
   assign q_low   = wk_ff[MEAN_W-1:0];
   assign q_adj   = q_low + MEAN_W'(rem_ff[DVR_W-1:0] != '0);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_PASS: begin
            mul_a = SMAG_W'(rd_mag);
            mul_b = SQ_W'(rd_mag);
         end
         ST_MUL_NSQ: begin
            mul_a = SMAG_W'(count_ff);
            mul_b = sq_ff;
         end
         ST_MUL_SS: begin
            mul_a = smag;
            mul_b = SQ_W'(smag);
         end
         ST_MUL_NN: begin
            mul_a = SMAG_W'(count_ff);
            mul_b = SQ_W'(count_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // shared subtractor operand select
   always_comb begin
      sub_a = '0;
      sub_b = '0;
      case (state_ff)
         ST_DIV_MEAN, ST_DIV_VAR: begin
            sub_a = SUB_W'({rem_ff[DVR_W-1:0], wk_ff[WK_W-1]});
            sub_b = SUB_W'(divisor);
         end
         ST_ROOT: begin
            sub_a = SUB_W'({rem_ff[RT_W:0], wk_ff[WK_W-1 -: 2]});
            sub_b = SUB_W'({root_ff, 2'b01});
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
   end

   assign diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign ge   = !diff[SUB_W];

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      abs_in      = abs_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      drop_in     = drop_ff;
      idx_in      = idx_ff;
      sq_in       = sq_ff;
      num_in      = num_ff;
      nsq_in      = nsq_ff;
      wk_in       = wk_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      step_in     = step_ff;
      mean_in     = mean_ff;
      mem_we      = 1'b0;
      issue       = 1'b0;
      out_load    = 1'b0;
      req_ready   = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_ff < CW'(MAX_SAMPLES)) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + 1'b1;
                  sum_in   = sum_ff + SUM_W'(req_sample);
                  abs_in   = abs_ff + SMAG_W'(smp_mag);
                  if (req_sample < min_ff) begin
                     min_in = req_sample;
                  end
                  if (req_sample > max_ff) begin
                     max_in = req_sample;
                  end
               end else begin
                  drop_in = 1'b1;
               end
               if (req_last_sample) begin
                  idx_in   = '0;
                  sq_in    = '0;
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            if (prod_vld_ff) begin
               sq_in = sq_ff + prod_ff[SQ_W-1:0];
            end
            if (idx_ff != count_ff) begin
               issue  = 1'b1;
               idx_in = idx_ff + 1'b1;
            end else if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = ST_MUL_NSQ;
            end
         end
         ST_MUL_NSQ: begin
            state_in = ST_MUL_SS;
         end
         ST_MUL_SS: begin
            num_in   = prod_ff[NUM_W-1:0];
            state_in = ST_MUL_NN;
         end
         ST_MUL_NN: begin
            num_in   = num_ff - prod_ff[NUM_W-1:0];
            state_in = ST_MEAN_INIT;
         end
         ST_MEAN_INIT: begin
            nsq_in   = prod_ff[DVR_W-1:0];
            wk_in    = WK_W'(smag) << Q_FRAC;
            rem_in   = '0;
            step_in  = STEP_W'(WK_W);
            state_in = ST_DIV_MEAN;
         end
         ST_DIV_MEAN: begin
            wk_in   = {wk_ff[WK_W-2:0], ge};
            rem_in  = ge ? diff[SUB_W-1:0] : sub_a;
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_MEAN_FIX;
            end
         end
         ST_MEAN_FIX: begin
            mean_in  = sum_ff[SUM_W-1] ? (~q_adj + MEAN_W'(1)) : q_low;
            wk_in    = WK_W'(num_ff) << VAR_FRAC;
            rem_in   = '0;
            step_in  = STEP_W'(WK_W);
            state_in = ST_DIV_VAR;
         end
         ST_DIV_VAR: begin
            wk_in   = {wk_ff[WK_W-2:0], ge};
            rem_in  = ge ? diff[SUB_W-1:0] : sub_a;
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               rem_in   = '0;
               root_in  = '0;
               step_in  = STEP_W'(RT_W);
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            wk_in   = {wk_ff[WK_W-3:0], 2'b00};
            rem_in  = ge ? diff[SUB_W-1:0] : sub_a;
            root_in = {root_ff[RT_W-2:0], ge};
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!out_vld_ff || rsp_ready) begin
               out_load = 1'b1;
               count_in = '0;
               sum_in   = '0;
               abs_in   = '0;
               min_in   = SAMPLE_TOP;
               max_in   = SAMPLE_BOTTOM;
               drop_in  = 1'b0;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rd_vld_in   = issue;
   assign prod_vld_in = rd_vld_ff;
   assign out_vld_in  = out_load | (out_vld_ff & !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         count_ff    <= '0;
         sum_ff      <= '0;
         abs_ff      <= '0;
         min_ff      <= SAMPLE_TOP;
         max_ff      <= SAMPLE_BOTTOM;
         drop_ff     <= 1'b0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         abs_ff      <= abs_in;
         min_ff      <= min_in;
         max_ff      <= max_in;
         drop_ff     <= drop_in;
         rd_vld_ff   <= rd_vld_in;
         prod_vld_ff <= prod_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      sq_ff   <= sq_in;
      num_ff  <= num_in;
      nsq_ff  <= nsq_in;
      wk_ff   <= wk_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
      mean_ff <= mean_in;
      prod_ff <= P_W'(mul_a) * P_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_mean_ff  <= mean_ff;
         out_std_ff   <= STD_W'(root_ff);
         out_min_ff   <= min_ff;
         out_max_ff   <= max_ff;
         out_total_ff <= TOTAL_W'(sum_ff);
         out_magt_ff  <= MAGT_W'(abs_ff);
         out_count_ff <= COUNT_W'(count_ff);
         out_drop_ff  <= drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[AW-1:0]] <= req_sample;
      end
      rd_data_ff <= mem[idx_ff[AW-1:0]];
   end

   assign rsp_valid           = out_vld_ff;
   assign rsp_mean_q8         = out_mean_ff;
   assign rsp_std_dev_q8      = out_std_ff;
   assign rsp_minimum         = out_min_ff;
   assign rsp_maximum         = out_max_ff;
   assign rsp_total           = out_total_ff;
   assign rsp_magnitude_total = out_magt_ff;
   assign rsp_sample_count    = out_count_ff;
   assign rsp_overflow        = out_drop_ff;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_mean_q8)
         && $stable(rsp_std_dev_q8) && $stable(rsp_sample_count)))
      else $error("result item changed while waiting");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SAMPLES))
      else $error("sample count beyond capacity");

   a_result_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_count != '0))
      else $error("result offered for an empty window");

   a_window_cleared: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (count_ff == '0 && !drop_ff && sum_ff == '0))
      else $error("window not cleared after result");

endmodule

`default_nettype wire
